// ----- design/lpcg_pkg.sv -----
// Shared constants, register codes and helper functions for the lidar polar-to-cartesian gate.
`timescale 1ns / 1ps
package lpcg_pkg;

  // 0.1 m in Q8.8 (nearest LSB)
  localparam logic [15:0] RANGE_MARGIN = 16'd26;
  // CORDIC gain inverse, Q0.32, limit value
  localparam logic [31:0] GAIN_INV     = 32'h9B74EDA8;
  localparam int          MAX_STAGES   = 24;
  // digit width of the serial multipliers
  localparam int          DIGIT        = 4;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_START_ANGLE = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_MIN_RANGE   = 3'd2;
  localparam logic [2:0] REG_MAX_RANGE   = 3'd3;
  localparam logic [2:0] REG_CELLS_PER_M = 3'd4;

  typedef logic signed [35:0] cord_t;   // CORDIC x / y, Q20.16
  typedef logic signed [33:0] ang_t;    // CORDIC z, 2^32 per turn

  // arctan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Q20.16 -> Q16.8, round half up, saturate to 24-bit signed
  function automatic logic [23:0] to_cells(input cord_t v);
    logic signed [36:0] s;
    logic signed [36:0] r;
    logic [23:0]        o;
    s = 37'(v) + 37'sd128;
    r = s >>> 8;
    if (r > 37'sd8388607) begin
      o = 24'h7FFFFF;
    end else if (r < -37'sd8388608) begin
      o = 24'h800000;
    end else begin
      o = r[23:0];
    end
    return o;
  endfunction

endpackage

// ----- design/lidar_polar_to_cartesian_gate_top.sv -----
// Top level of the lidar range gate and polar-to-cartesian converter.
`timescale 1ns / 1ps
// Takes one range sample per input transfer and returns exactly one point per
// sample. The beam angle reloads from start_angle on scan_start and advances
// by angle_step after every sample, kept or not. A sample is kept when it lies
// strictly above min_range and strictly below max_range - 0.1 m. A rejected
// sample goes from the accepting state straight to the output state, where
// its point (0,0, kept low) is loaded once the output register is free. A
// kept sample goes through a 4-bit-per-cycle serial multiplier for range *
// cells_per_meter, a second 4-bit digit-serial multiply by the CORDIC gain
// inverse, a seed step, CORDIC_STAGES iterations of one shared rotation stage
// (capped at 24) and the same output state. No new sample is accepted until
// the current one has left the output state. The result sits in an output
// register, so the next sample is taken while a finished point waits; only a
// further finished point waits for the output side. Registers on the APB port
// at byte address 4*i: start_angle, angle_step, min_range, max_range,
// cells_per_meter; write them only while the block is idle.
module lidar_polar_to_cartesian_gate_top
  import lpcg_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // range sample input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_range_sample,
  input  logic               in_scan_start,
  input  logic               in_scan_end,
  // point output
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_x_cells,
  output logic signed [23:0] out_y_cells,
  output logic               out_kept,
  output logic               out_end_of_scan,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // stages beyond the table length act as the last table length
  localparam int NSTG  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int ROT_W = $clog2(NSTG);
  localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(NSTG - 1);
  localparam int MUL1_STEPS = 16 / DIGIT;
  localparam int MUL2_STEPS = 32 / DIGIT;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_SEED = 3'd3;
  localparam logic [2:0] S_ROT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // ---------------- configuration registers ----------------
  logic [15:0] start_angle_r, angle_step_r, min_range_r, max_range_r, cpm_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= 16'd0;
      angle_step_r  <= 16'd0;
      min_range_r   <= 16'd0;
      max_range_r   <= 16'd7680;
      cpm_r         <= 16'd10240;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_START_ANGLE: start_angle_r <= pwdata[15:0];
        REG_ANGLE_STEP:  angle_step_r  <= pwdata[15:0];
        REG_MIN_RANGE:   min_range_r   <= pwdata[15:0];
        REG_MAX_RANGE:   max_range_r   <= pwdata[15:0];
        REG_CELLS_PER_M: cpm_r         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_ANGLE: prdata = {16'd0, start_angle_r};
      REG_ANGLE_STEP:  prdata = {16'd0, angle_step_r};
      REG_MIN_RANGE:   prdata = {16'd0, min_range_r};
      REG_MAX_RANGE:   prdata = {16'd0, max_range_r};
      REG_CELLS_PER_M: prdata = {16'd0, cpm_r};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- control ----------------
  logic [2:0]       state_r, state_nxt;
  logic [2:0]       dig_cnt_r, dig_cnt_nxt;     // multiplier digit count
  logic [ROT_W-1:0] rot_cnt_r, rot_cnt_nxt;     // CORDIC iteration
  logic [15:0]      beam_angle_r, beam_angle_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath
  logic [15:0] rng_sh_r, rng_sh_nxt;    // range digits, MSB first
  logic [31:0] p_r, p_nxt;              // scaled range, then shifted out LSB first
  logic [31:0] hi_r, hi_nxt;            // high word of p * GAIN_INV
  logic        rnd_r, rnd_nxt;          // product bit 31 for rounding
  logic [15:0] ang_r, ang_nxt;
  logic        keep_r, keep_nxt;
  logic        last_r, last_nxt;
  cord_t       x_r, x_nxt, y_r, y_nxt;
  ang_t        z_r, z_nxt;

  logic [23:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic        okept_r, okept_nxt, oend_r, oend_nxt;

  logic              in_xfer, out_free;
  logic [15:0]       ang_cur;
  logic signed [17:0] upper_lim;
  logic              keep_cur;
  logic [35:0]       mul2_sum;
  logic [32:0]       x_seed;
  logic              fold;
  logic [31:0]       zu;
  cord_t             dx, dy;
  ang_t              at;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign ang_cur   = in_scan_start ? start_angle_r : beam_angle_r;
  assign upper_lim = $signed({2'b00, max_range_r}) - $signed({2'b00, RANGE_MARGIN});
  assign keep_cur  = (in_range_sample > min_range_r) &&
                     ($signed({2'b00, in_range_sample}) < upper_lim);

  // one digit of p times the gain inverse, accumulator shifted down a digit
  assign mul2_sum = {4'd0, hi_r} + 36'(p_r[DIGIT-1:0]) * 36'(GAIN_INV);

  // seed: round, fold left half plane by a half turn
  assign x_seed = {1'b0, hi_r} + 33'(rnd_r);
  assign fold   = ang_r[15] ^ ang_r[14];
  assign zu     = {ang_r[15] ^ fold, ang_r[14:0], 16'd0};

  assign dx = y_r >>> rot_cnt_r;
  assign dy = x_r >>> rot_cnt_r;
  assign at = ang_t'({2'b00, atan_lut(5'(rot_cnt_r))});

  always_comb begin
    state_nxt      = state_r;
    dig_cnt_nxt    = dig_cnt_r;
    rot_cnt_nxt    = rot_cnt_r;
    beam_angle_nxt = beam_angle_r;
    out_valid_nxt  = out_valid_r;
    rng_sh_nxt     = rng_sh_r;
    p_nxt          = p_r;
    hi_nxt         = hi_r;
    rnd_nxt        = rnd_r;
    ang_nxt        = ang_r;
    keep_nxt       = keep_r;
    last_nxt       = last_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    okept_nxt      = okept_r;
    oend_nxt       = oend_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ang_nxt        = ang_cur;
          beam_angle_nxt = ang_cur + angle_step_r;
          keep_nxt       = keep_cur;
          last_nxt       = in_scan_end;
          rng_sh_nxt     = in_range_sample;
          p_nxt          = 32'd0;
          hi_nxt         = 32'd0;
          dig_cnt_nxt    = 3'd0;
          state_nxt      = keep_cur ? S_MUL1 : S_FIN;
        end
      end
      S_MUL1: begin
        p_nxt       = {p_r[31-DIGIT:0], {DIGIT{1'b0}}} +
                      32'(rng_sh_r[15 -: DIGIT]) * 32'(cpm_r);
        rng_sh_nxt  = {rng_sh_r[15-DIGIT:0], {DIGIT{1'b0}}};
        dig_cnt_nxt = dig_cnt_r + 3'd1;
        if (dig_cnt_r == 3'(MUL1_STEPS - 1)) begin
          dig_cnt_nxt = 3'd0;
          state_nxt   = S_MUL2;
        end
      end
      S_MUL2: begin
        hi_nxt      = mul2_sum[35:DIGIT];
        rnd_nxt     = mul2_sum[DIGIT-1];
        p_nxt       = {{DIGIT{1'b0}}, p_r[31:DIGIT]};
        dig_cnt_nxt = dig_cnt_r + 3'd1;
        if (dig_cnt_r == 3'(MUL2_STEPS - 1)) begin
          dig_cnt_nxt = 3'd0;
          state_nxt   = S_SEED;
        end
      end
      S_SEED: begin
        x_nxt       = fold ? -$signed({3'b000, x_seed}) : $signed({3'b000, x_seed});
        y_nxt       = '0;
        z_nxt       = ang_t'($signed(zu));
        rot_cnt_nxt = '0;
        state_nxt   = S_ROT;
      end
      S_ROT: begin
        if (!z_r[33]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        rot_cnt_nxt = rot_cnt_r + ROT_W'(1);
        if (rot_cnt_r == ROT_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait here only while an earlier point is still held
        if (out_free) begin
          ox_nxt        = keep_r ? to_cells(x_r) : 24'd0;
          oy_nxt        = keep_r ? to_cells(y_r) : 24'd0;
          okept_nxt     = keep_r;
          oend_nxt      = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dig_cnt_r    <= 3'd0;
      rot_cnt_r    <= '0;
      beam_angle_r <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dig_cnt_r    <= dig_cnt_nxt;
      rot_cnt_r    <= rot_cnt_nxt;
      beam_angle_r <= beam_angle_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rng_sh_r <= rng_sh_nxt;
    p_r      <= p_nxt;
    hi_r     <= hi_nxt;
    rnd_r    <= rnd_nxt;
    ang_r    <= ang_nxt;
    keep_r   <= keep_nxt;
    last_r   <= last_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    okept_r  <= okept_nxt;
    oend_r   <= oend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_x_cells     = $signed(ox_r);
  assign out_y_cells     = $signed(oy_r);
  assign out_kept        = okept_r;
  assign out_end_of_scan = oend_r;

endmodule
